// ===== design/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// Deploy/retract sequencer package
// Shared types, codes and constants of the deploy/retract sequencer.
// ----------------------------------------------------------------------------
package drs_pkg;

	// Width of the wait tick counter.
	localparam int COUNT_BITS = 16;
	// Width used to compare the counter with the 16-bit wait limit.
	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	// Register addresses and values on the controllers.
	localparam logic [7:0] ADDR_SOFT_STOP = 8'd189;
	localparam logic [7:0] ADDR_TARGET    = 8'd127;
	localparam logic [7:0] ADDR_MODE      = 8'd126;
	localparam logic [7:0] STOP_ACTIVE    = 8'd0;
	localparam logic [7:0] STOP_RELEASE   = 8'd1;
	localparam logic       TGT_DRIVE      = 1'b0;
	localparam logic       TGT_MECH       = 1'b1;

	// Mechanism state codes.
	localparam logic [7:0] MECH_CTRL    = 8'd0;
	localparam logic [7:0] MECH_HOLD    = 8'd1;
	localparam logic [7:0] MECH_INIT    = 8'd2;
	localparam logic [7:0] MECH_WAIT    = 8'd5;
	localparam logic [7:0] MECH_ASCEND1 = 8'd6;
	localparam logic [7:0] MECH_FINISH  = 8'd8;

	// Reset values of the configuration registers.
	localparam logic [15:0] WAIT_LIMIT_RST = 16'd500;
	localparam logic [7:0]  ERROR_CODE_RST = 8'd10;
	localparam logic [7:0]  AUTO_MODE_RST  = 8'd1;

	typedef enum logic [1:0] {
		CFG_WAIT_LIMIT = 2'd0,
		CFG_ERROR_CODE = 2'd1,
		CFG_AUTO_MODE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_TRIGGER  = 2'd1,
		CMD_LOCK_SET = 2'd2,
		CMD_LOCK_CLR = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		STEP_IDLE         = 4'd0,
		STEP_STOP_SET     = 4'd1,
		STEP_STATE_CHECK  = 4'd2,
		STEP_SET_AUTO     = 4'd3,
		STEP_DEPLOY_WR    = 4'd4,
		STEP_WAIT_DEPLOY  = 4'd5,
		STEP_CAMERA       = 4'd6,
		STEP_RETRACT_WR   = 4'd7,
		STEP_WAIT_RETRACT = 4'd8,
		STEP_STOP_RELEASE = 4'd9
	} step_t;

	typedef enum logic [2:0] {
		CAUSE_NONE         = 3'd0,
		CAUSE_UNREAD       = 3'd1,
		CAUSE_ERROR        = 3'd2,
		CAUSE_BUSY         = 3'd3,
		CAUSE_BAD_STATE    = 3'd4,
		CAUSE_SLOT         = 3'd5,
		CAUSE_WRITE        = 3'd6,
		CAUSE_WAIT_TIMEOUT = 3'd7
	} cause_t;

	typedef enum logic [1:0] {
		WAIT_HOLD  = 2'd0,
		WAIT_CLEAR = 2'd1,
		WAIT_BUMP  = 2'd2
	} wait_op_t;

	// Configuration register set.
	typedef struct packed {
		logic [15:0] wait_limit;
		logic [7:0]  error_state_code;
		logic [7:0]  auto_mode_value;
	} cfg_t;

	// One input request.
	typedef struct packed {
		cmd_t       cmd;
		logic       write_done;
		logic       write_ok;
		logic       state_valid;
		logic [7:0] mech_state;
		logic       slot_free;
	} item_t;

	// Register write issued toward a controller.
	typedef struct packed {
		logic       req;
		logic       target;
		logic [7:0] addr;
		logic [7:0] value;
	} wr_t;

	// One result.
	typedef struct packed {
		wr_t         wr;
		step_t       step;
		logic [15:0] wait_count;
		logic        locked_out;
		logic        motion_paused;
		cause_t      abort_cause;
	} res_t;

endpackage

// ===== design/deploy_retract_sequencer_unit.sv =====
// Deploy/retract sequencer, top level.
// A request is held in the input register until the result register can load its result.
// Throughput: one request per cycle unless res_stall holds the result; the step
// logic between the input and result registers updates the sequence state.
// Reset: arst_n clears the sequence to idle, unlocked, not paused, counter zero,
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Deploy/retract sequencer unit
// Input register, sequence core, result register and configuration port.
// ----------------------------------------------------------------------------
module deploy_retract_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Request channel.
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic        write_done,
	input  logic        write_ok,
	input  logic        state_valid,
	input  logic [7:0]  mech_state,
	input  logic        slot_free,
	// Result channel.
	output logic        res_valid,
	input  logic        res_stall,
	output logic        write_req,
	output logic        write_target,
	output logic [7:0]  write_addr,
	output logic [7:0]  write_value,
	output logic [3:0]  step,
	output logic [15:0] wait_count,
	output logic        locked_out,
	output logic        motion_paused,
	output logic [2:0]  abort_cause
);
	import drs_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_c;
	res_t  res_s2;
	logic  valid_s2;
	logic  adv;
	logic  fire;

	// Configuration is always accepted.
	assign cfg_ready = 1'b1;

	drs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The result register can load when it is empty or being taken.
	assign adv       = !valid_s2 || !res_stall;
	assign fire      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1.cmd         <= cmd_t'(cmd);
			item_s1.write_done  <= write_done;
			item_s1.write_ok    <= write_ok;
			item_s1.state_valid <= state_valid;
			item_s1.mech_state  <= mech_state;
			item_s1.slot_free   <= slot_free;
		end
	end

	drs_seq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_c;
		end
	end

	assign res_valid     = valid_s2;
	assign write_req     = res_s2.wr.req;
	assign write_target  = res_s2.wr.target;
	assign write_addr    = res_s2.wr.addr;
	assign write_value   = res_s2.wr.value;
	assign step          = res_s2.step;
	assign wait_count    = res_s2.wait_count;
	assign locked_out    = res_s2.locked_out;
	assign motion_paused = res_s2.motion_paused;
	assign abort_cause   = res_s2.abort_cause;

endmodule

// ===== design/drs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Deploy/retract sequencer configuration registers
// Holds wait limit, error state code and auto mode value.
// ----------------------------------------------------------------------------
module drs_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [15:0]   wr_data,
	output drs_pkg::cfg_t cfg
);
	import drs_pkg::*;

	cfg_t cfg_q;

	// Decode the register index; writes to an unknown index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_limit       <= WAIT_LIMIT_RST;
			cfg_q.error_state_code <= ERROR_CODE_RST;
			cfg_q.auto_mode_value  <= AUTO_MODE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_WAIT_LIMIT: cfg_q.wait_limit       <= wr_data;
				CFG_ERROR_CODE: cfg_q.error_state_code <= wr_data[7:0];
				CFG_AUTO_MODE:  cfg_q.auto_mode_value  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/drs_seq_core.sv =====
// ----------------------------------------------------------------------------
// Deploy/retract sequencer core
// Sequence state registers and the step logic for one request.
// ----------------------------------------------------------------------------
module drs_seq_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  drs_pkg::item_t item,
	input  drs_pkg::cfg_t  cfg,
	output drs_pkg::res_t  res
);
	import drs_pkg::*;

	typedef struct packed {
		cause_t   cause;
		wr_t      wr;
		wait_op_t wait_op;
		logic     adv;
	} act_t;

	step_t                  step_q, step_d;
	logic [COUNT_BITS-1:0]  wait_q, wait_d, wait_inc;
	logic                   lock_q, lock_d;
	logic                   pend_q, pend_d;
	logic                   paused_q, paused_d;
	logic                   over;
	act_t                   act;

	function automatic wr_t mk_write(input logic slot, input logic tgt,
		input logic [7:0] addr, input logic [7:0] val);
		wr_t w;
		w = '0;
		if (slot) begin
			w.req    = 1'b1;
			w.target = tgt;
			w.addr   = addr;
			w.value  = val;
		end
		return w;
	endfunction

	// Saturating increment of the wait counter and the timeout compare.
	assign wait_inc = (wait_q == '1) ? wait_q : wait_q + COUNT_BITS'(1);
	assign over     = CMP_W'(wait_inc) > CMP_W'(cfg.wait_limit);

	// Decide the action of this request: abort cause, write and counter use.
	always_comb begin
		act         = '0;
		act.cause   = CAUSE_NONE;
		act.wait_op = WAIT_HOLD;
		if (item.cmd == CMD_TICK) begin
			unique case (step_q)
				STEP_IDLE: begin
					if (pend_q && !lock_q) begin
						act.adv = 1'b1;
						act.wr  = mk_write(item.slot_free, TGT_DRIVE, ADDR_SOFT_STOP,
							STOP_ACTIVE);
					end
				end
				STEP_STOP_SET: begin
					if (item.write_done) begin
						if (item.write_ok) begin
							act.adv     = 1'b1;
							act.wait_op = WAIT_CLEAR;
						end else begin
							act.cause = CAUSE_WRITE;
						end
					end
				end
				STEP_STATE_CHECK: begin
					if (!item.state_valid) begin
						act.wait_op = WAIT_BUMP;
						if (over) act.cause = CAUSE_UNREAD;
					end else if (item.mech_state == cfg.error_state_code) begin
						act.cause = CAUSE_ERROR;
					end else if (item.mech_state >= MECH_INIT &&
						item.mech_state <= MECH_FINISH) begin
						act.cause = CAUSE_BUSY;
					end else if (item.mech_state != MECH_CTRL &&
						item.mech_state != MECH_HOLD) begin
						act.cause = CAUSE_BAD_STATE;
					end else if (!item.slot_free) begin
						act.cause = CAUSE_SLOT;
					end else begin
						act.adv     = 1'b1;
						act.wait_op = WAIT_CLEAR;
						act.wr      = mk_write(1'b1, TGT_MECH, ADDR_MODE,
							cfg.auto_mode_value);
					end
				end
				STEP_SET_AUTO: begin
					if (item.write_done) begin
						if (!item.write_ok) begin
							act.cause = CAUSE_WRITE;
						end else if (!item.slot_free) begin
							act.cause = CAUSE_SLOT;
						end else begin
							act.adv     = 1'b1;
							act.wait_op = WAIT_CLEAR;
							act.wr      = mk_write(1'b1, TGT_MECH, ADDR_TARGET, MECH_INIT);
						end
					end
				end
				STEP_DEPLOY_WR, STEP_RETRACT_WR: begin
					if (item.write_done) begin
						if (item.write_ok) begin
							act.adv     = 1'b1;
							act.wait_op = WAIT_CLEAR;
						end else begin
							act.cause = CAUSE_WRITE;
						end
					end
				end
				STEP_WAIT_DEPLOY: begin
					if (!item.state_valid) begin
						act.wait_op = WAIT_BUMP;
						if (over) act.cause = CAUSE_UNREAD;
					end else if (item.mech_state == cfg.error_state_code) begin
						act.cause = CAUSE_ERROR;
					end else if (item.mech_state == MECH_WAIT) begin
						act.adv     = 1'b1;
						act.wait_op = WAIT_CLEAR;
					end else begin
						act.wait_op = WAIT_BUMP;
						if (over) act.cause = CAUSE_WAIT_TIMEOUT;
					end
				end
				STEP_CAMERA: begin
					if (!item.slot_free) begin
						act.cause = CAUSE_SLOT;
					end else begin
						act.adv     = 1'b1;
						act.wait_op = WAIT_CLEAR;
						act.wr      = mk_write(1'b1, TGT_MECH, ADDR_TARGET, MECH_ASCEND1);
					end
				end
				STEP_WAIT_RETRACT: begin
					if (!item.state_valid) begin
						act.wait_op = WAIT_BUMP;
						if (over) act.cause = CAUSE_UNREAD;
					end else if (item.mech_state == cfg.error_state_code) begin
						act.cause = CAUSE_ERROR;
					end else if (item.mech_state == MECH_FINISH ||
						item.mech_state == MECH_CTRL) begin
						act.adv     = 1'b1;
						act.wait_op = WAIT_CLEAR;
						act.wr      = mk_write(item.slot_free, TGT_DRIVE, ADDR_SOFT_STOP,
							STOP_RELEASE);
					end else begin
						act.wait_op = WAIT_BUMP;
						if (over) act.cause = CAUSE_WAIT_TIMEOUT;
					end
				end
				STEP_STOP_RELEASE: begin
					act.adv = item.write_done;
				end
				default: begin
					act.adv = 1'b1;
				end
			endcase
			// An abort with the soft stop held asks for its release.
			if (act.cause != CAUSE_NONE && paused_q) begin
				act.wr = mk_write(item.slot_free, TGT_DRIVE, ADDR_SOFT_STOP,
					STOP_RELEASE);
			end
		end
	end

	// Next state of the sequence, counter and flags.
	always_comb begin
		step_d   = step_q;
		lock_d   = lock_q;
		pend_d   = pend_q;
		paused_d = paused_q;
		unique case (act.wait_op)
			WAIT_CLEAR: wait_d = '0;
			WAIT_BUMP:  wait_d = wait_inc;
			default:    wait_d = wait_q;
		endcase
		unique case (item.cmd)
			CMD_TRIGGER:  pend_d = 1'b1;
			CMD_LOCK_SET: lock_d = 1'b1;
			CMD_LOCK_CLR: lock_d = 1'b0;
			CMD_TICK: begin
				if (step_q == STEP_IDLE) pend_d = 1'b0;
				if (act.cause != CAUSE_NONE) begin
					lock_d = 1'b1;
					step_d = paused_q ? STEP_STOP_RELEASE : STEP_IDLE;
				end else if (act.adv) begin
					unique case (step_q)
						STEP_IDLE:         step_d = STEP_STOP_SET;
						STEP_STOP_SET: begin
							step_d   = STEP_STATE_CHECK;
							paused_d = 1'b1;
						end
						STEP_STATE_CHECK:  step_d = STEP_SET_AUTO;
						STEP_SET_AUTO:     step_d = STEP_DEPLOY_WR;
						STEP_DEPLOY_WR:    step_d = STEP_WAIT_DEPLOY;
						STEP_WAIT_DEPLOY:  step_d = STEP_CAMERA;
						STEP_CAMERA:       step_d = STEP_RETRACT_WR;
						STEP_RETRACT_WR:   step_d = STEP_WAIT_RETRACT;
						STEP_WAIT_RETRACT: step_d = STEP_STOP_RELEASE;
						STEP_STOP_RELEASE: begin
							step_d   = STEP_IDLE;
							paused_d = 1'b0;
							lock_d   = 1'b1;
						end
						default:           step_d = STEP_IDLE;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Sequence state registers, updated once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_IDLE;
			wait_q   <= '0;
			lock_q   <= 1'b0;
			pend_q   <= 1'b0;
			paused_q <= 1'b0;
		end else if (fire) begin
			step_q   <= step_d;
			wait_q   <= wait_d;
			lock_q   <= lock_d;
			pend_q   <= pend_d;
			paused_q <= paused_d;
		end
	end

	// Result of this request, taken from the updated state.
	always_comb begin
		res.wr            = act.wr;
		res.step          = step_d;
		res.wait_count    = 16'(wait_d);
		res.locked_out    = lock_d;
		res.motion_paused = paused_d;
		res.abort_cause   = act.cause;
	end

endmodule

// ===== design/drs_checker.sv =====
// ----------------------------------------------------------------------------
// Deploy/retract sequencer checker
// Port-level assertions on the sequencer, attached by bind.
// ----------------------------------------------------------------------------
module drs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic        write_req,
	input logic        write_target,
	input logic [7:0]  write_addr,
	input logic [7:0]  write_value,
	input logic [3:0]  step,
	input logic        locked_out,
	input logic        motion_paused,
	input logic [2:0]  abort_cause
);
	import drs_pkg::*;

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(step) && $stable(write_addr))
		else $error("stalled result changed");

	// An abort always leaves the sequence locked.
	a_abort_lock: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && abort_cause != CAUSE_NONE |-> locked_out)
		else $error("abort without lock");

	// An abort ends in idle or in the stop release step.
	a_abort_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && abort_cause != CAUSE_NONE |->
		step == STEP_IDLE || step == STEP_STOP_RELEASE)
		else $error("abort left sequence mid-way");

	// Past the stop set step the soft stop is held.
	a_paused: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && step >= STEP_STATE_CHECK && step <= STEP_STOP_RELEASE |->
		motion_paused)
		else $error("sequence running without soft stop");

	// Without a write the write fields are zero.
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !write_req |->
		!write_target && write_addr == 8'd0 && write_value == 8'd0)
		else $error("write fields set without a write");

endmodule

bind deploy_retract_sequencer_unit drs_checker u_drs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.write_req     (write_req),
	.write_target  (write_target),
	.write_addr    (write_addr),
	.write_value   (write_value),
	.step          (step),
	.locked_out    (locked_out),
	.motion_paused (motion_paused),
	.abort_cause   (abort_cause)
);
